// ===== rtl/core/task_slot_scheduler_assert.svh =====
// Assertion macros for the task slot scheduler.
`ifndef TASK_SLOT_SCHEDULER_ASSERT_SVH
`define TASK_SLOT_SCHEDULER_ASSERT_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define TSS_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tss: assertion failed");

// Next-cycle implication.
`define TSS_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tss: assertion failed");

`endif

// ===== rtl/core/tss_pkg.sv =====
package tss_pkg;

    localparam logic [2:0] ST_FREE     = 3'd0;
    localparam logic [2:0] ST_READY    = 3'd1;
    localparam logic [2:0] ST_RUNNING  = 3'd2;
    localparam logic [2:0] ST_SLEEPING = 3'd3;
    localparam logic [2:0] ST_DONE     = 3'd5;

    localparam logic [2:0] K_SPAWN    = 3'd0;
    localparam logic [2:0] K_RESCHED  = 3'd1;
    localparam logic [2:0] K_PARKED   = 3'd2;
    localparam logic [2:0] K_KILL     = 3'd3;
    localparam logic [2:0] K_REAP     = 3'd4;
    localparam logic [2:0] K_AFFINITY = 3'd5;

    localparam logic [1:0] PARK_SLEEP = 2'd1;
    localparam logic [1:0] PARK_DONE  = 2'd2;

    localparam logic [1:0] AFF_ANY   = 2'd0;
    localparam logic [1:0] AFF_CORE0 = 2'd1;

    localparam logic [1:0] STS_OK      = 2'd0;
    localparam logic [1:0] STS_REFUSED = 2'd1;
    localparam logic [1:0] STS_NO_SLOT = 2'd2;

    localparam logic [2:0] ACT_NONE     = 3'd0;
    localparam logic [2:0] ACT_CONTINUE = 3'd1;
    localparam logic [2:0] ACT_SWITCH   = 3'd2;
    localparam logic [2:0] ACT_WAIT     = 3'd3;
    localparam logic [2:0] ACT_RELEASE  = 3'd4;

    localparam logic [30:0] PID_INIT = 31'd1;
    localparam logic [30:0] PID_NEXT_RST = 31'd2;

    typedef struct packed {
        logic [2:0]  state;
        logic [30:0] pid;
        logic [1:0]  aff;
        logic [31:0] wake;
        logic        live;
        logic        kill;
        logic [31:0] swc;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

    localparam t_slot SLOT0_RST = '{state: ST_RUNNING, pid: PID_INIT, aff: AFF_CORE0,
                                    wake: 32'd0, live: 1'b1, kill: 1'b0, swc: 32'd0};

    typedef struct packed {
        logic used;
        logic match;
        logic passed;
        logic runnable;
    } t_eval;

endpackage

// ===== rtl/core/tss_ram.sv =====
module tss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/tss_slot_eval.sv =====
module tss_slot_eval import tss_pkg::*; (
    input  t_slot       i_word,
    input  logic        i_core,
    input  logic [31:0] i_now,
    input  logic [30:0] i_key,
    output t_eval       o_ev
);

    logic [31:0] w_diff;
    logic        w_aff_ok;
    logic        w_state_ok;

    assign w_diff = i_now - i_word.wake;

    always_comb begin
        if (i_word.aff == AFF_ANY) begin
            w_aff_ok = 1'b1;
        end else if (i_word.aff == AFF_CORE0) begin
            w_aff_ok = !i_core;
        end else begin
            w_aff_ok = i_core;
        end
    end

    assign o_ev.used   = i_word.state != ST_FREE;
    assign o_ev.match  = o_ev.used && (i_word.pid == i_key);
    assign o_ev.passed = !w_diff[31];
    assign w_state_ok  = (i_word.state == ST_READY) ||
                         ((i_word.state == ST_SLEEPING) && o_ev.passed);
    assign o_ev.runnable = !i_word.live && w_state_ok && w_aff_ok;

endmodule

// ===== rtl/core/task_slot_scheduler.sv =====
// Channel   Dir  Handshake                  Payload
// s_axis    in   s_axis_tvalid/tready       tdata: kind, core, target_pid, affinity,
//                                           park_as, sleep_ms, now_ms
// m_axis    out  m_axis_tvalid/tready       tdata: status, action, result_pid, result_slot
// cfg       in   i_cfg_valid/o_cfg_ready    i_cfg_data: shell_pid
//
// Spawn, parked, kill, reap, affinity: one scan of the slot RAM.
// Reschedule: two scans of the slot RAM (find, then choose).
// Slot RAM has one read port and is scanned one entry per cycle.
// Reset: per-slot valid bits clear at once, no clearing pass; input is taken right away.
// A result waiting on m_axis stalls only the last step of the next item.
module task_slot_scheduler import tss_pkg::*; #(
    parameter int TASK_SLOTS = 16,
    parameter int CORE_COUNT = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // kind[2:0], core[3], target_pid[34:4], affinity[36:35], park_as[38:37],
    // sleep_ms[70:39], now_ms[102:71], zero pad[103]
    input  logic [103:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[1:0], action[4:2], result_pid[35:5], result_slot[39:36]
    output logic [39:0]  m_axis_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [30:0]  i_cfg_data
);

    localparam int SW  = $clog2(TASK_SLOTS);
    localparam int CIW = (CORE_COUNT > 1) ? $clog2(CORE_COUNT) : 1;
    localparam logic [SW:0] N_SLOTS = (SW + 1)'(TASK_SLOTS);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN1 = 6'b000010,
        S_WB    = 6'b000100,
        S_SCAN2 = 6'b001000,
        S_FIN   = 6'b010000,
        S_OUT   = 6'b100000
    } t_fsm;

    t_fsm r_fsm, n_fsm;

    logic [2:0]  r_kind;
    logic        r_core;
    logic [30:0] r_tpid;
    logic [1:0]  r_aff;
    logic [1:0]  r_park;
    logic [31:0] r_sleep;
    logic [31:0] r_now;

    logic [30:0] r_shell;
    logic [30:0] r_npid, n_npid;
    logic [30:0] r_run_pid [CORE_COUNT];
    logic [30:0] n_run_pid [CORE_COUNT];
    logic [CORE_COUNT-1:0] r_idle, n_idle;
    logic [TASK_SLOTS-1:0] r_valid;

    logic [SW:0]   r_cnt, n_cnt;
    logic          r_ev, n_ev;
    logic          r_ev_vld, n_ev_vld;
    logic [SW-1:0] r_eidx, n_eidx;

    logic          r_hit, n_hit;
    logic [SW-1:0] r_hidx, n_hidx;
    t_slot         r_hword, n_hword;
    logic          r_fr_hit, n_fr_hit;
    logic [SW-1:0] r_fr_idx, n_fr_idx;
    logic          r_dn_hit, n_dn_hit;
    logic [SW-1:0] r_dn_idx, n_dn_idx;
    logic [30:0]   r_dn_pid, n_dn_pid;

    logic [SW:0]   r_start, n_start;
    t_slot         r_me_word, n_me_word;
    logic          r_hi_hit, n_hi_hit;
    logic [SW-1:0] r_hi_idx, n_hi_idx;
    t_slot         r_hi_word, n_hi_word;
    logic          r_lo_hit, n_lo_hit;
    logic [SW-1:0] r_lo_idx, n_lo_idx;
    t_slot         r_lo_word, n_lo_word;

    logic [1:0]    r_res_sts, n_res_sts;
    logic [2:0]    r_res_act, n_res_act;
    logic [30:0]   r_res_pid, n_res_pid;
    logic [SW-1:0] r_res_slot, n_res_slot;

    logic          r_ov, n_ov;
    logic [1:0]    r_o_sts;
    logic [2:0]    r_o_act;
    logic [30:0]   r_o_pid;
    logic [3:0]    r_o_slot;

    logic              w_we;
    logic [SW-1:0]     w_waddr;
    t_slot             w_wdata;
    logic [SW-1:0]     w_raddr;
    logic [SLOT_W-1:0] w_ram_q;
    t_slot             w_rd;
    t_slot             w_ev_word;
    t_eval             w_ev;
    logic [CIW-1:0]    w_c;
    logic              w_core_bit;
    logic [30:0]       w_key;
    logic              w_issue;
    logic              w_scan_done;
    logic              w_load;
    logic [SW+3:0]     w_slot_ext;
    t_slot             w_tmp;
    logic              w_nx_hit;
    logic [SW-1:0]     w_nx_idx;
    t_slot             w_nx_word;
    logic [30:0]       w_pid_inc;

    assign w_c        = (CORE_COUNT > 1) ? CIW'(r_core) : '0;
    assign w_core_bit = (CORE_COUNT > 1) ? r_core : 1'b0;
    assign w_key      = (r_kind == K_RESCHED) ? r_run_pid[w_c] : r_tpid;
    assign w_issue    = ((r_fsm == S_SCAN1) || (r_fsm == S_SCAN2)) && (r_cnt < N_SLOTS);
    assign w_raddr    = r_cnt[SW-1:0];
    assign w_scan_done = (r_cnt == N_SLOTS) && !r_ev;
    assign w_rd       = r_ev_vld ? t_slot'(w_ram_q) :
                        ((r_eidx == '0) ? SLOT0_RST : t_slot'('0));
    assign w_ev_word  = (r_fsm == S_FIN) ? r_me_word : w_rd;
    assign w_load     = !r_ov || m_axis_tready;
    assign w_nx_hit   = r_hi_hit || r_lo_hit;
    assign w_nx_idx   = r_hi_hit ? r_hi_idx : r_lo_idx;
    assign w_nx_word  = r_hi_hit ? r_hi_word : r_lo_word;
    assign w_pid_inc  = r_npid + 31'd1;
    assign w_slot_ext = {4'd0, r_res_slot};

    tss_ram #(.WIDTH(SLOT_W), .DEPTH(TASK_SLOTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_ram_q)
    );

    tss_slot_eval u_eval (
        .i_word (w_ev_word),
        .i_core (w_core_bit),
        .i_now  (r_now),
        .i_key  (w_key),
        .o_ev   (w_ev)
    );

    always_comb begin
        n_fsm      = r_fsm;
        n_npid     = r_npid;
        n_run_pid  = r_run_pid;
        n_idle     = r_idle;
        n_cnt      = r_cnt;
        n_ev       = 1'b0;
        n_ev_vld   = r_ev_vld;
        n_eidx     = r_eidx;
        n_hit      = r_hit;
        n_hidx     = r_hidx;
        n_hword    = r_hword;
        n_fr_hit   = r_fr_hit;
        n_fr_idx   = r_fr_idx;
        n_dn_hit   = r_dn_hit;
        n_dn_idx   = r_dn_idx;
        n_dn_pid   = r_dn_pid;
        n_start    = r_start;
        n_me_word  = r_me_word;
        n_hi_hit   = r_hi_hit;
        n_hi_idx   = r_hi_idx;
        n_hi_word  = r_hi_word;
        n_lo_hit   = r_lo_hit;
        n_lo_idx   = r_lo_idx;
        n_lo_word  = r_lo_word;
        n_res_sts  = r_res_sts;
        n_res_act  = r_res_act;
        n_res_pid  = r_res_pid;
        n_res_slot = r_res_slot;
        n_ov       = r_ov && !m_axis_tready;
        w_we       = 1'b0;
        w_waddr    = r_hidx;
        w_wdata    = r_hword;
        w_tmp      = r_hword;

        if (w_issue) begin
            n_cnt    = r_cnt + 1'b1;
            n_ev     = 1'b1;
            n_eidx   = w_raddr;
            n_ev_vld = r_valid[w_raddr];
        end

        case (r_fsm)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_cnt      = '0;
                    n_hit      = 1'b0;
                    n_fr_hit   = 1'b0;
                    n_dn_hit   = 1'b0;
                    n_res_sts  = STS_OK;
                    n_res_act  = ACT_NONE;
                    n_res_pid  = '0;
                    n_res_slot = '0;
                    if (s_axis_tdata[2:0] > K_AFFINITY) begin
                        n_res_sts = STS_REFUSED;
                        n_fsm     = S_OUT;
                    end else begin
                        n_fsm = S_SCAN1;
                    end
                end
            end
            S_SCAN1: begin
                if (r_ev) begin
                    if (r_kind == K_SPAWN) begin
                        if (w_rd.state == ST_FREE && !r_fr_hit) begin
                            n_fr_hit = 1'b1;
                            n_fr_idx = r_eidx;
                        end
                        if (w_rd.state == ST_DONE && (!r_dn_hit || w_rd.pid < r_dn_pid)) begin
                            n_dn_hit = 1'b1;
                            n_dn_idx = r_eidx;
                            n_dn_pid = w_rd.pid;
                        end
                    end else if (w_ev.match && !r_hit && w_key != '0) begin
                        n_hit   = 1'b1;
                        n_hidx  = r_eidx;
                        n_hword = w_rd;
                    end
                end
                if (w_scan_done) begin
                    n_fsm = S_WB;
                end
            end
            S_WB: begin
                n_fsm = S_OUT;
                case (r_kind)
                    K_SPAWN: begin
                        if (!r_fr_hit && !r_dn_hit) begin
                            n_res_sts = STS_NO_SLOT;
                        end else begin
                            w_we    = 1'b1;
                            w_waddr = r_fr_hit ? r_fr_idx : r_dn_idx;
                            w_wdata = '{state: ST_READY, pid: r_npid, aff: r_aff,
                                        wake: 32'd0, live: 1'b0, kill: 1'b0, swc: 32'd0};
                            n_npid     = (w_pid_inc == '0) ? PID_INIT : w_pid_inc;
                            n_res_pid  = r_npid;
                            n_res_slot = w_waddr;
                        end
                    end
                    K_RESCHED: begin
                        if (r_hword.state == ST_RUNNING) begin
                            if (r_park == PARK_SLEEP) begin
                                w_tmp.state = ST_SLEEPING;
                                w_tmp.wake  = r_now + r_sleep;
                            end else if (r_park == PARK_DONE) begin
                                w_tmp.state = ST_DONE;
                            end else begin
                                w_tmp.state = ST_READY;
                            end
                        end
                        w_we      = r_hit;
                        w_wdata   = w_tmp;
                        n_me_word = w_tmp;
                        if (r_hit && !(r_hword.state == ST_DONE && !r_idle[w_c])) begin
                            n_start = {1'b0, r_hidx} + 1'b1;
                        end else begin
                            n_start = '0;
                        end
                        n_cnt    = '0;
                        n_hi_hit = 1'b0;
                        n_lo_hit = 1'b0;
                        n_fsm    = S_SCAN2;
                    end
                    default: begin
                        if (!r_hit) begin
                            n_res_sts = STS_REFUSED;
                        end else if (r_kind == K_PARKED) begin
                            w_tmp.live = 1'b0;
                            w_we       = 1'b1;
                        end else if (r_kind == K_KILL) begin
                            if (r_hword.pid == PID_INIT || r_hword.state == ST_DONE ||
                                (r_shell != '0 && r_hword.pid == r_shell)) begin
                                n_res_sts = STS_REFUSED;
                            end else begin
                                w_tmp.kill = 1'b1;
                                if (r_hword.state == ST_SLEEPING) begin
                                    w_tmp.wake  = r_now;
                                    w_tmp.state = ST_READY;
                                end
                                w_we = 1'b1;
                            end
                        end else if (r_kind == K_REAP) begin
                            if (r_hword.state != ST_DONE) begin
                                n_res_sts = STS_REFUSED;
                            end else begin
                                w_tmp.state = ST_FREE;
                                w_we        = 1'b1;
                            end
                        end else begin
                            w_tmp.aff = r_aff;
                            w_we      = 1'b1;
                        end
                        w_wdata = w_tmp;
                    end
                endcase
            end
            S_SCAN2: begin
                if (r_ev && w_ev.used && w_ev.runnable) begin
                    if ({1'b0, r_eidx} >= r_start) begin
                        if (!r_hi_hit) begin
                            n_hi_hit  = 1'b1;
                            n_hi_idx  = r_eidx;
                            n_hi_word = w_rd;
                        end
                    end else if (!r_lo_hit) begin
                        n_lo_hit  = 1'b1;
                        n_lo_idx  = r_eidx;
                        n_lo_word = w_rd;
                    end
                end
                if (w_scan_done) begin
                    n_fsm = S_FIN;
                end
            end
            S_FIN: begin
                n_fsm   = S_OUT;
                w_waddr = r_hidx;
                w_tmp   = r_me_word;
                w_tmp.state = ST_RUNNING;
                w_wdata = w_tmp;
                if (!w_nx_hit) begin
                    if (r_hit && (r_me_word.state == ST_READY ||
                        (r_me_word.state == ST_SLEEPING && w_ev.passed))) begin
                        w_we       = 1'b1;
                        n_res_act  = ACT_CONTINUE;
                        n_res_pid  = r_me_word.pid;
                        n_res_slot = r_hidx;
                    end else if (r_hit && r_me_word.state == ST_SLEEPING) begin
                        n_res_act = ACT_WAIT;
                    end else if (r_hit && r_me_word.state == ST_DONE) begin
                        if (r_idle[w_c]) begin
                            n_idle[w_c]    = 1'b0;
                            n_run_pid[w_c] = '0;
                            n_res_act      = ACT_RELEASE;
                        end else begin
                            n_res_act = ACT_WAIT;
                        end
                    end
                end else if (r_hit && w_nx_idx == r_hidx) begin
                    w_we       = 1'b1;
                    n_res_act  = ACT_CONTINUE;
                    n_res_pid  = r_me_word.pid;
                    n_res_slot = r_hidx;
                end else begin
                    w_tmp       = w_nx_word;
                    w_tmp.state = ST_RUNNING;
                    w_tmp.live  = 1'b1;
                    w_tmp.swc   = w_nx_word.swc + 32'd1;
                    w_we        = 1'b1;
                    w_waddr     = w_nx_idx;
                    w_wdata     = w_tmp;
                    n_run_pid[w_c] = w_nx_word.pid;
                    if (!r_hit) begin
                        n_idle[w_c] = 1'b1;
                    end
                    n_res_act  = ACT_SWITCH;
                    n_res_pid  = w_nx_word.pid;
                    n_res_slot = w_nx_idx;
                end
            end
            S_OUT: begin
                if (w_load) begin
                    n_ov  = 1'b1;
                    n_fsm = S_IDLE;
                end
            end
            default: begin
                n_fsm = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm     <= S_IDLE;
            r_shell   <= '0;
            r_npid    <= PID_NEXT_RST;
            r_idle    <= '0;
            r_valid   <= '0;
            r_ov      <= 1'b0;
            r_ev      <= 1'b0;
            r_cnt     <= '0;
            for (int k = 0; k < CORE_COUNT; k++) begin
                r_run_pid[k] <= (k == 0) ? PID_INIT : '0;
            end
        end else begin
            r_fsm     <= n_fsm;
            r_npid    <= n_npid;
            r_idle    <= n_idle;
            r_ov      <= n_ov;
            r_ev      <= n_ev;
            r_cnt     <= n_cnt;
            r_run_pid <= n_run_pid;
            if (i_cfg_valid) begin
                r_shell <= i_cfg_data;
            end
            if (w_we) begin
                r_valid[w_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_fsm == S_IDLE && s_axis_tvalid) begin
            r_kind  <= s_axis_tdata[2:0];
            r_core  <= s_axis_tdata[3];
            r_tpid  <= s_axis_tdata[34:4];
            r_aff   <= s_axis_tdata[36:35];
            r_park  <= s_axis_tdata[38:37];
            r_sleep <= s_axis_tdata[70:39];
            r_now   <= s_axis_tdata[102:71];
        end
        r_ev_vld   <= n_ev_vld;
        r_eidx     <= n_eidx;
        r_hit      <= n_hit;
        r_hidx     <= n_hidx;
        r_hword    <= n_hword;
        r_fr_hit   <= n_fr_hit;
        r_fr_idx   <= n_fr_idx;
        r_dn_hit   <= n_dn_hit;
        r_dn_idx   <= n_dn_idx;
        r_dn_pid   <= n_dn_pid;
        r_start    <= n_start;
        r_me_word  <= n_me_word;
        r_hi_hit   <= n_hi_hit;
        r_hi_idx   <= n_hi_idx;
        r_hi_word  <= n_hi_word;
        r_lo_hit   <= n_lo_hit;
        r_lo_idx   <= n_lo_idx;
        r_lo_word  <= n_lo_word;
        r_res_sts  <= n_res_sts;
        r_res_act  <= n_res_act;
        r_res_pid  <= n_res_pid;
        r_res_slot <= n_res_slot;
        if (r_fsm == S_OUT && w_load) begin
            r_o_sts  <= r_res_sts;
            r_o_act  <= r_res_act;
            r_o_pid  <= r_res_pid;
            r_o_slot <= w_slot_ext[3:0];
        end
    end

    assign s_axis_tready = r_fsm == S_IDLE;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {r_o_slot, r_o_pid, r_o_act, r_o_sts};

endmodule

// ===== rtl/core/tss_checker.sv =====
`include "task_slot_scheduler_assert.svh"

module tss_checker import tss_pkg::*; (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [39:0]  m_axis_tdata
);

    `TSS_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `TSS_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                    m_axis_tvalid && $stable(m_axis_tdata))
    `TSS_ASSERT_IMP(a_status_code, m_axis_tvalid, m_axis_tdata[1:0] <= STS_NO_SLOT)
    `TSS_ASSERT_IMP(a_action_ok, m_axis_tvalid && m_axis_tdata[4:2] != ACT_NONE,
                    m_axis_tdata[1:0] == STS_OK)
    `TSS_ASSERT_IMP(a_action_code, m_axis_tvalid, m_axis_tdata[4:2] <= ACT_RELEASE)

endmodule

bind task_slot_scheduler tss_checker u_tss_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/tb_task_slot_scheduler.sv =====
module tb_task_slot_scheduler;
    import tss_pkg::*;

    localparam int NSLOT = 16;
    localparam int NCORE = 2;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [3:0]  slot;
        logic [30:0] pid;
        logic [2:0]  action;
        logic [1:0]  status;
    } t_reply;

    class sched_scoreboard;
        logic [30:0] shell;
        logic [2:0]  st[NSLOT];
        logic [30:0] pid[NSLOT];
        logic [1:0]  aff[NSLOT];
        logic [31:0] wake[NSLOT];
        bit          live[NSLOT];
        bit          kflag[NSLOT];
        logic [31:0] swc[NSLOT];
        logic [30:0] run_pid[NCORE];
        bit          idle_ctx[NCORE];
        logic [30:0] next_pid;
        t_reply      pending[$];
        int          errors;

        function void reset_state();
            for (int i = 0; i < NSLOT; i++) begin
                st[i] = ST_FREE; pid[i] = '0; aff[i] = AFF_ANY; wake[i] = '0;
                live[i] = 0; kflag[i] = 0; swc[i] = '0;
            end
            st[0] = ST_RUNNING; pid[0] = 31'd1; aff[0] = AFF_CORE0; live[0] = 1;
            run_pid[0] = 31'd1; run_pid[1] = '0; idle_ctx[0] = 0; idle_ctx[1] = 0;
            next_pid = 31'd2; shell = '0; errors = 0;
        endfunction

        function int lookup(logic [30:0] p);
            for (int i = 0; i < NSLOT; i++)
                if (st[i] != ST_FREE && pid[i] == p) return i;
            return -1;
        endfunction

        function bit passed(logic [31:0] now, logic [31:0] w);
            logic [31:0] d;
            d = now - w;
            return !d[31];
        endfunction

        function bit runnable(int i, int c, logic [31:0] now);
            if (live[i]) return 0;
            if (st[i] == ST_SLEEPING) begin
                if (!passed(now, wake[i])) return 0;
            end else if (st[i] != ST_READY) return 0;
            if (aff[i] == AFF_ANY) return 1;
            if (aff[i] == AFF_CORE0) return c == 0;
            return c == 1;
        endfunction

        function int pick(int c, logic [30:0] after, logic [31:0] now);
            int s, j;
            s = 0;
            for (int i = 0; i < NSLOT; i++)
                if (st[i] != ST_FREE && pid[i] == after) begin
                    s = i + 1;
                    break;
                end
            for (int n = 0; n < NSLOT; n++) begin
                j = (s + n) % NSLOT;
                if (st[j] != ST_FREE && runnable(j, c, now)) return j;
            end
            return -1;
        endfunction

        function void note_item(logic [103:0] d);
            logic [2:0] kind;
            int c, t, me, nx;
            logic [30:0] tp, after;
            logic [1:0] af, pk;
            logic [31:0] slp, now;
            bit was_done;
            t_reply r;
            kind = d[2:0]; c = {31'd0, d[3]}; tp = d[34:4]; af = d[36:35]; pk = d[38:37];
            slp = d[70:39]; now = d[102:71];
            r = '0;
            if (kind == K_SPAWN) begin
                t = -1;
                for (int i = 0; i < NSLOT && t < 0; i++) if (st[i] == ST_FREE) t = i;
                if (t < 0)
                    for (int i = 0; i < NSLOT; i++)
                        if (st[i] == ST_DONE && (t < 0 || pid[i] < pid[t])) t = i;
                if (t < 0) r.status = STS_NO_SLOT;
                else begin
                    pid[t] = next_pid;
                    next_pid = next_pid + 31'd1;
                    if (next_pid == '0) next_pid = 31'd1;
                    st[t] = ST_READY; aff[t] = af; wake[t] = '0; live[t] = 0;
                    kflag[t] = 0; swc[t] = '0;
                    r.pid = pid[t]; r.slot = 4'(t);
                end
            end else if (kind == K_RESCHED) begin
                me = run_pid[c] != '0 ? lookup(run_pid[c]) : -1;
                was_done = me >= 0 && st[me] == ST_DONE;
                if (me >= 0 && st[me] == ST_RUNNING) begin
                    if (pk == PARK_SLEEP) begin
                        st[me] = ST_SLEEPING; wake[me] = now + slp;
                    end else if (pk == PARK_DONE) st[me] = ST_DONE;
                    else st[me] = ST_READY;
                end
                after = me >= 0 ? pid[me] : '0;
                if (was_done && !idle_ctx[c]) after = '0;
                nx = pick(c, after, now);
                if (nx < 0) begin
                    if (me >= 0 && (st[me] == ST_READY ||
                        (st[me] == ST_SLEEPING && passed(now, wake[me])))) begin
                        st[me] = ST_RUNNING; r.action = ACT_CONTINUE;
                        r.pid = pid[me]; r.slot = 4'(me);
                    end else if (me >= 0 && st[me] == ST_SLEEPING) r.action = ACT_WAIT;
                    else if (me >= 0 && st[me] == ST_DONE) begin
                        if (idle_ctx[c]) begin
                            idle_ctx[c] = 0; run_pid[c] = '0; r.action = ACT_RELEASE;
                        end else r.action = ACT_WAIT;
                    end
                end else if (nx == me) begin
                    st[me] = ST_RUNNING; r.action = ACT_CONTINUE;
                    r.pid = pid[me]; r.slot = 4'(me);
                end else begin
                    st[nx] = ST_RUNNING; live[nx] = 1; swc[nx] = swc[nx] + 32'd1;
                    run_pid[c] = pid[nx];
                    if (me < 0) idle_ctx[c] = 1;
                    r.action = ACT_SWITCH; r.pid = pid[nx]; r.slot = 4'(nx);
                end
            end else if (kind <= K_AFFINITY) begin
                t = lookup(tp);
                if (t < 0) r.status = STS_REFUSED;
                else if (kind == K_PARKED) live[t] = 0;
                else if (kind == K_KILL) begin
                    if (pid[t] == PID_INIT || (shell != '0 && pid[t] == shell) ||
                        st[t] == ST_DONE)
                        r.status = STS_REFUSED;
                    else begin
                        kflag[t] = 1;
                        if (st[t] == ST_SLEEPING) begin
                            wake[t] = now; st[t] = ST_READY;
                        end
                    end
                end else if (kind == K_REAP) begin
                    if (st[t] != ST_DONE) r.status = STS_REFUSED;
                    else st[t] = ST_FREE;
                end else aff[t] = af;
            end else r.status = STS_REFUSED;
            pending.push_back(r);
        endfunction

        task check_reply(logic [39:0] d);
            t_reply got, exp_r;
            got = d;
            if (pending.size() == 0) begin
                report_err("result with nothing pending");
                return;
            end
            exp_r = pending.pop_front();
            if (got.status !== exp_r.status) report_err("status mismatch");
            if (got.action !== exp_r.action) report_err("action mismatch");
            if (got.pid !== exp_r.pid) report_err("result_pid mismatch");
            if (got.slot !== exp_r.slot) report_err("result_slot mismatch");
        endtask

        task report_err(string msg);
            errors++;
            $display("ERROR %0t: %s", $realtime, msg);
        endtask
    endclass

    logic         i_clk, i_rst_n;
    logic         s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready;
    logic [103:0] s_axis_tdata;
    logic [39:0]  m_axis_tdata;
    logic         i_cfg_valid, o_cfg_ready;
    logic [30:0]  i_cfg_data;

    sched_scoreboard sb;
    int in_idle, out_stall, cycles;
    logic [30:0] live_pids[$];

    task_slot_scheduler i_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL task_slot_scheduler");
            $finish;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_reply(m_axis_tdata);
    end

    always @(negedge i_clk) m_axis_tready <= ($urandom_range(0, 99) >= out_stall);

    function logic [30:0] any_pid();
        int k;
        k = $urandom_range(0, 9);
        if (k < 7 && live_pids.size() > 0)
            return live_pids[$urandom_range(0, live_pids.size() - 1)];
        if (k == 7) return 31'h7fffffff;
        if (k == 8) return 31'd1;
        return 31'($urandom);
    endfunction

    task automatic send_item(logic [2:0] kind, logic core, logic [30:0] tp,
                             logic [1:0] af, logic [1:0] pk, logic [31:0] slp,
                             logic [31:0] now);
        logic [103:0] d;
        d = {1'b0, now, slp, pk, af, tp, core, kind};
        do @(negedge i_clk); while ($urandom_range(0, 99) < in_idle);
        s_axis_tvalid <= 1;
        s_axis_tdata <= d;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_item(d);
        if (kind == K_SPAWN && sb.pending[$].status == STS_OK) begin
            live_pids.push_back(sb.pending[$].pid);
            if (live_pids.size() > 40) void'(live_pids.pop_front());
        end
        @(negedge i_clk);
        s_axis_tvalid <= 0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_shell(logic [30:0] v);
        i_cfg_valid <= 1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.shell = v;
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    logic [31:0] clock_ms;

    task automatic random_items(int n);
        int k;
        logic [2:0] kind;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            if (k < 20) kind = K_SPAWN;
            else if (k < 55) kind = K_RESCHED;
            else if (k < 67) kind = K_PARKED;
            else if (k < 77) kind = K_KILL;
            else if (k < 89) kind = K_REAP;
            else if (k < 97) kind = K_AFFINITY;
            else kind = 3'($urandom_range(6, 7));
            clock_ms = clock_ms + $urandom_range(0, 40);
            if ($urandom_range(0, 30) == 0) clock_ms = $urandom;
            send_item(kind, 1'($urandom_range(0, 1)), any_pid(), 2'($urandom_range(0, 3)),
                      2'($urandom_range(0, 3)),
                      ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 100),
                      clock_ms);
        end
    endtask

    initial begin
        sb = new();
        sb.reset_state();
        cycles = 0; in_idle = 0; out_stall = 0; clock_ms = '0;
        i_rst_n = 0; s_axis_tvalid = 0; s_axis_tdata = '0;
        m_axis_tready = 0; i_cfg_valid = 0; i_cfg_data = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        write_shell(31'd0);
        // directed
        send_item(K_RESCHED, 1'b0, 31'd0, AFF_ANY, 2'd0, 32'd0, 32'd0);
        send_item(K_SPAWN, 1'b0, 31'd0, AFF_ANY, 2'd0, 32'd0, 32'd0);
        send_item(K_SPAWN, 1'b1, 31'd0, 2'd3, 2'd0, 32'd0, 32'd0);
        send_item(K_SPAWN, 1'b0, 31'd0, AFF_CORE0, 2'd0, 32'd0, 32'd0);
        send_item(K_RESCHED, 1'b1, 31'd0, AFF_ANY, 2'd0, 32'd0, 32'd5);
        send_item(K_RESCHED, 1'b0, 31'd0, AFF_ANY, PARK_SLEEP, 32'hffffffff, 32'hffffffff);
        send_item(K_KILL, 1'b0, 31'd1, AFF_ANY, 2'd0, 32'd0, 32'd6);
        send_item(K_KILL, 1'b0, 31'd2, AFF_ANY, 2'd0, 32'd0, 32'd6);
        send_item(K_KILL, 1'b0, 31'h7fffffff, AFF_ANY, 2'd0, 32'd0, 32'd6);
        send_item(K_PARKED, 1'b0, 31'd1, AFF_ANY, 2'd0, 32'd0, 32'd7);
        send_item(K_RESCHED, 1'b1, 31'd0, AFF_ANY, PARK_DONE, 32'd0, 32'd8);
        send_item(K_RESCHED, 1'b1, 31'd0, AFF_ANY, 2'd3, 32'd0, 32'd9);
        send_item(K_REAP, 1'b0, 31'd3, AFF_ANY, 2'd0, 32'd0, 32'd9);
        send_item(K_REAP, 1'b0, 31'd2, AFF_ANY, 2'd0, 32'd0, 32'd9);
        send_item(K_AFFINITY, 1'b0, 31'd4, 2'd2, 2'd0, 32'd0, 32'd9);
        send_item(3'd6, 1'b1, 31'h7fffffff, 2'd3, 2'd3, 32'hffffffff, 32'hffffffff);
        send_item(3'd7, 1'b0, 31'd0, AFF_ANY, 2'd0, 32'd0, 32'd0);
        for (int i = 0; i < 17; i++)
            send_item(K_SPAWN, 1'b0, 31'd0, AFF_ANY, 2'd0, 32'd0, 32'd10);
        drain();
        write_shell(31'h7fffffff);
        send_item(K_KILL, 1'b0, 31'h7fffffff, AFF_ANY, 2'd0, 32'd0, 32'd11);
        drain();
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin in_idle = 0;  out_stall = 0;  end
                1: begin in_idle = 75; out_stall = 0;  end
                2: begin in_idle = 0;  out_stall = 75; end
                3: begin in_idle = 25; out_stall = 25; end
                default: begin in_idle = 0; out_stall = 0; end
            endcase
            random_items(280);
            drain();
            write_shell(live_pids.size() > 0 ? live_pids[$] : 31'd2);
        end
        drain();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("PASS task_slot_scheduler");
        end else begin
            $display("FAIL task_slot_scheduler");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/tss_pkg.sv
rtl/core/tss_ram.sv
rtl/core/tss_slot_eval.sv
rtl/core/task_slot_scheduler.sv
rtl/core/tss_checker.sv
tb/tb_task_slot_scheduler.sv
